FILE: sv/key_deque_with_delete_all_defines.svh
// Assertion macros for the key deque checker.
// Depends on nothing; included by kdq_checker.sv.
`ifndef KEY_DEQUE_WITH_DELETE_ALL_DEFINES_SVH
`define KEY_DEQUE_WITH_DELETE_ALL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KDQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define KDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: sv/kdq_pkg.sv
// Shared constants, codes and types of the key deque.
// No dependencies; used by every module of the block.
package kdq_pkg;

   localparam int DEPTH     = 16;
   localparam int KEY_CHARS = 9;
   localparam int KEY_BITS  = KEY_CHARS * 5;

   // Fixed port widths
   localparam int KEY_W     = 45;
   localparam int MODE_W    = 3;
   localparam int INDEX_W   = 4;
   localparam int CNT_OUT_W = 5;
   localparam int STATUS_W  = 2;

   // Derived internal widths
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   // Command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Request mode codes
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_DELETE     = MODE_W'(4);
   localparam logic [MODE_W-1:0] MODE_READ       = MODE_W'(5);

   typedef enum logic [2:0] {
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_BACK,
      OP_POP_FRONT,
      OP_DELETE,
      OP_READ,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_BITS-1:0]  key;
      logic [INDEX_W-1:0]   index;
   } cmd_type;

endpackage

FILE: sv/kdq_front.sv
// Front end: classify an incoming request into a decoded command.
// Depends on kdq_pkg.
module kdq_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kdq_pkg::MODE_W-1:0]    req_mode,
   input  logic [kdq_pkg::KEY_W-1:0]     req_key,
   input  logic [kdq_pkg::INDEX_W-1:0]   req_index,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output kdq_pkg::cmd_type              cmd
);

   kdq_pkg::op_type op;

   // decode mode; unused codes become a no-op
   always_comb begin
      unique case (req_mode)
         kdq_pkg::MODE_PUSH_BACK:  op = kdq_pkg::OP_PUSH_BACK;
         kdq_pkg::MODE_PUSH_FRONT: op = kdq_pkg::OP_PUSH_FRONT;
         kdq_pkg::MODE_POP_BACK:   op = kdq_pkg::OP_POP_BACK;
         kdq_pkg::MODE_POP_FRONT:  op = kdq_pkg::OP_POP_FRONT;
         kdq_pkg::MODE_DELETE:     op = kdq_pkg::OP_DELETE;
         kdq_pkg::MODE_READ:       op = kdq_pkg::OP_READ;
         default:                  op = kdq_pkg::OP_NOP;
      endcase
   end

   assign cmd.op    = op;
   assign cmd.key   = kdq_pkg::KEY_BITS'(req_key);
   assign cmd.index = req_index;

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

endmodule

FILE: sv/kdq_cmd_q.sv
// Short command queue that decouples the front end from the back end.
// Depends on kdq_pkg.
module kdq_cmd_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  kdq_pkg::cmd_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output kdq_pkg::cmd_type  pop_data
);

   kdq_pkg::cmd_type               mem_ff [kdq_pkg::Q_DEPTH];
   logic [kdq_pkg::Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [kdq_pkg::Q_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [kdq_pkg::Q_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   assign push_ready = (cnt_ff != kdq_pkg::Q_CNT_W'(kdq_pkg::Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == kdq_pkg::Q_PTR_W'(kdq_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + kdq_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == kdq_pkg::Q_PTR_W'(kdq_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + kdq_pkg::Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + kdq_pkg::Q_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - kdq_pkg::Q_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload slots: no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/kdq_back.sv
// Back end: entry store, command execution, delete-all scan, result register.
// Depends on kdq_pkg.
module kdq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  kdq_pkg::cmd_type                cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [kdq_pkg::CNT_OUT_W-1:0]   rsp_size_after,
   output logic [kdq_pkg::CNT_OUT_W-1:0]   rsp_removed_count,
   output logic [kdq_pkg::KEY_W-1:0]       rsp_entry_read,
   output logic [kdq_pkg::STATUS_W-1:0]    rsp_status
);

   kdq_pkg::back_state_type              state_ff, state_in;
   logic [kdq_pkg::KEY_BITS-1:0]         store_ff [kdq_pkg::DEPTH];
   logic [kdq_pkg::KEY_BITS-1:0]         store_in [kdq_pkg::DEPTH];
   logic [kdq_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [kdq_pkg::CNT_W-1:0]            pos_ff, pos_in;
   logic [kdq_pkg::CNT_W-1:0]            removed_ff, removed_in;
   logic [kdq_pkg::KEY_BITS-1:0]         match_key_ff, match_key_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [kdq_pkg::CNT_W-1:0]            rsp_size_ff, rsp_size_in;
   logic [kdq_pkg::CNT_W-1:0]            rsp_rem_ff, rsp_rem_in;
   logic [kdq_pkg::KEY_BITS-1:0]         rsp_rd_ff, rsp_rd_in;
   kdq_pkg::status_type                  rsp_st_ff, rsp_st_in;

   logic                                 out_free, fire, load_rsp;
   logic                                 is_full, is_empty, range_bad, scan_done, hit;
   logic                                 shift_up, shift_down, write_tail;
   logic [kdq_pkg::CNT_W-1:0]            shift_from;
   logic [kdq_pkg::IDX_W-1:0]            rd_addr;
   logic [kdq_pkg::KEY_BITS-1:0]         rd_data;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == kdq_pkg::BK_IDLE) && out_free;
   assign fire      = cmd_valid && cmd_ready;

   assign is_full   = (count_ff == kdq_pkg::CNT_W'(kdq_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);
   assign range_bad = (kdq_pkg::CMP_W'(cmd.index) >= kdq_pkg::CMP_W'(count_ff));
   assign scan_done = (pos_ff == count_ff);

   // single read port: scan position while deleting, request index otherwise
   assign rd_addr = (state_ff == kdq_pkg::BK_SCAN) ? pos_ff[kdq_pkg::IDX_W-1:0] :
                    kdq_pkg::IDX_W'(cmd.index);
   assign rd_data = store_ff[rd_addr];
   assign hit     = (rd_data == match_key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kdq_pkg::BK_IDLE: begin
            if (fire && cmd.op == kdq_pkg::OP_DELETE) begin
               state_in = kdq_pkg::BK_SCAN;
            end
         end
         kdq_pkg::BK_SCAN: begin
            if (scan_done && out_free) begin
               state_in = kdq_pkg::BK_IDLE;
            end
         end
      endcase
   end

   // execution and result selection
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      removed_in   = removed_ff;
      match_key_in = match_key_ff;
      shift_up     = 1'b0;
      shift_down   = 1'b0;
      shift_from   = '0;
      write_tail   = 1'b0;
      load_rsp     = 1'b0;
      rsp_size_in  = count_ff;
      rsp_rem_in   = '0;
      rsp_rd_in    = '0;
      rsp_st_in    = kdq_pkg::ST_OK;
      unique case (state_ff)
         kdq_pkg::BK_IDLE: begin
            if (fire) begin
               unique case (cmd.op)
                  kdq_pkg::OP_PUSH_BACK: begin
                     load_rsp = 1'b1;
                     if (is_full) begin
                        rsp_st_in = kdq_pkg::ST_FULL;
                     end else begin
                        write_tail  = 1'b1;
                        count_in    = count_ff + kdq_pkg::CNT_W'(1);
                        rsp_size_in = count_in;
                     end
                  end
                  kdq_pkg::OP_PUSH_FRONT: begin
                     load_rsp = 1'b1;
                     if (is_full) begin
                        rsp_st_in = kdq_pkg::ST_FULL;
                     end else begin
                        shift_up    = 1'b1;
                        count_in    = count_ff + kdq_pkg::CNT_W'(1);
                        rsp_size_in = count_in;
                     end
                  end
                  kdq_pkg::OP_POP_BACK: begin
                     load_rsp = 1'b1;
                     if (is_empty) begin
                        rsp_st_in = kdq_pkg::ST_EMPTY;
                     end else begin
                        count_in    = count_ff - kdq_pkg::CNT_W'(1);
                        rsp_size_in = count_in;
                        rsp_rem_in  = kdq_pkg::CNT_W'(1);
                     end
                  end
                  kdq_pkg::OP_POP_FRONT: begin
                     load_rsp = 1'b1;
                     if (is_empty) begin
                        rsp_st_in = kdq_pkg::ST_EMPTY;
                     end else begin
                        shift_down  = 1'b1;
                        count_in    = count_ff - kdq_pkg::CNT_W'(1);
                        rsp_size_in = count_in;
                        rsp_rem_in  = kdq_pkg::CNT_W'(1);
                     end
                  end
                  kdq_pkg::OP_DELETE: begin
                     pos_in       = '0;
                     removed_in   = '0;
                     match_key_in = cmd.key;
                  end
                  kdq_pkg::OP_READ: begin
                     load_rsp = 1'b1;
                     if (range_bad) begin
                        rsp_st_in = kdq_pkg::ST_RANGE;
                     end else begin
                        rsp_rd_in = rd_data;
                     end
                  end
                  kdq_pkg::OP_NOP: begin
                     load_rsp = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         kdq_pkg::BK_SCAN: begin
            if (scan_done) begin
               load_rsp   = out_free;
               rsp_rem_in = removed_ff;
            end else if (hit) begin
               // drop the matching entry, close the gap, stay at this position
               shift_down = 1'b1;
               shift_from = pos_ff;
               count_in   = count_ff - kdq_pkg::CNT_W'(1);
               removed_in = removed_ff + kdq_pkg::CNT_W'(1);
            end else begin
               pos_in = pos_ff + kdq_pkg::CNT_W'(1);
            end
         end
      endcase
   end

   // store update: fixed-neighbor shifts plus tail write
   always_comb begin
      for (int i = 0; i < kdq_pkg::DEPTH; i++) begin
         store_in[i] = store_ff[i];
      end
      if (shift_up) begin
         store_in[0] = cmd.key;
         for (int i = 1; i < kdq_pkg::DEPTH; i++) begin
            store_in[i] = store_ff[i-1];
         end
      end
      if (shift_down) begin
         for (int i = 0; i < kdq_pkg::DEPTH - 1; i++) begin
            if (kdq_pkg::CNT_W'(i) >= shift_from) begin
               store_in[i] = store_ff[i+1];
            end
         end
      end
      if (write_tail) begin
         for (int i = 0; i < kdq_pkg::DEPTH; i++) begin
            if (kdq_pkg::CNT_W'(i) == count_ff) begin
               store_in[i] = cmd.key;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kdq_pkg::BK_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < kdq_pkg::DEPTH; i++) begin
         store_ff[i] <= store_in[i];
      end
      match_key_ff <= match_key_in;
      if (load_rsp) begin
         rsp_size_ff <= rsp_size_in;
         rsp_rem_ff  <= rsp_rem_in;
         rsp_rd_ff   <= rsp_rd_in;
         rsp_st_ff   <= rsp_st_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_size_after    = kdq_pkg::CNT_OUT_W'(rsp_size_ff);
   assign rsp_removed_count = kdq_pkg::CNT_OUT_W'(rsp_rem_ff);
   assign rsp_entry_read    = kdq_pkg::KEY_W'(rsp_rd_ff);
   assign rsp_status        = rsp_st_ff;

endmodule

FILE: sv/key_deque_with_delete_all.sv
// Key deque with delete-all: an ordered list of packed keys.
// Request channel (req_*): valid/ready; one transfer carries mode, key and index.
// Result channel (rsp_*): valid/ready; exactly one result transfer per request,
// in request order, with size after, removed count, entry read and status.
// A request passes through the command queue and then the back end before its
// result is registered. Push, pop, read and unused modes sustain one request
// per cycle while rsp_ready stays high and no delete-all is in progress.
// Delete-all examines one entry per cycle in the back end and holds the back end
// until it has checked every entry of the list.
// Reset clears the list size, the command queue and the result valid flag; the
// entry store itself is not cleared and is only read below the size.
// When the receiver stalls, the result holds in the output register while the
// two-entry command queue keeps taking requests; once that fills, req_ready
// drops until the back end drains it.
// Depends on kdq_pkg, kdq_front, kdq_cmd_q and kdq_back.
module key_deque_with_delete_all (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [kdq_pkg::MODE_W-1:0]      req_mode,
   input  logic [kdq_pkg::KEY_W-1:0]       req_key,
   input  logic [kdq_pkg::INDEX_W-1:0]     req_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [kdq_pkg::CNT_OUT_W-1:0]   rsp_size_after,
   output logic [kdq_pkg::CNT_OUT_W-1:0]   rsp_removed_count,
   output logic [kdq_pkg::KEY_W-1:0]       rsp_entry_read,
   output logic [kdq_pkg::STATUS_W-1:0]    rsp_status
);

   // front end to queue
   logic              fq_valid, fq_ready;
   kdq_pkg::cmd_type  fq_cmd;
   // queue to back end
   logic              qb_valid, qb_ready;
   kdq_pkg::cmd_type  qb_cmd;

   // Classify the request: map mode onto an operation, pass the key through.
   kdq_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_key   (req_key),
      .req_index (req_index),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd       (fq_cmd)
   );

   // Hold decoded commands while the back end is busy scanning or stalled.
   kdq_cmd_q u_cmd_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_cmd)
   );

   // Execute against the entry store and drive the result register.
   kdq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (qb_valid),
      .cmd_ready         (qb_ready),
      .cmd               (qb_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_size_after    (rsp_size_after),
      .rsp_removed_count (rsp_removed_count),
      .rsp_entry_read    (rsp_entry_read),
      .rsp_status        (rsp_status)
   );

endmodule

FILE: sv/kdq_checker.sv
// Port-level checker for the key deque, bound to the top level.
// Depends on kdq_pkg and key_deque_with_delete_all_defines.svh.
`include "key_deque_with_delete_all_defines.svh"

module kdq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [kdq_pkg::CNT_OUT_W-1:0]   rsp_size_after,
   input logic [kdq_pkg::CNT_OUT_W-1:0]   rsp_removed_count,
   input logic [kdq_pkg::KEY_W-1:0]       rsp_entry_read,
   input logic [kdq_pkg::STATUS_W-1:0]    rsp_status
);

   // a stalled result stays valid
   `KDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a rejected push only happens on a full list
   `KDQ_ASSERT_IMPLY(a_full_size, clock, reset,
      rsp_valid && rsp_status == kdq_pkg::ST_FULL,
      rsp_size_after == kdq_pkg::CNT_OUT_W'(kdq_pkg::DEPTH) && rsp_removed_count == '0)

   // an empty pop removes nothing and leaves nothing
   `KDQ_ASSERT_IMPLY(a_empty_pop, clock, reset,
      rsp_valid && rsp_status == kdq_pkg::ST_EMPTY,
      rsp_size_after == '0 && rsp_removed_count == '0 && rsp_entry_read == '0)

   // read data and removals never come with an error status
   `KDQ_ASSERT_IMPLY(a_read_ok, clock, reset,
      rsp_valid && rsp_entry_read != '0,
      rsp_status == kdq_pkg::ST_OK && rsp_removed_count == '0)

   `KDQ_ASSERT_IMPLY(a_remove_ok, clock, reset,
      rsp_valid && rsp_removed_count != '0,
      rsp_status == kdq_pkg::ST_OK)

endmodule

bind key_deque_with_delete_all kdq_checker u_kdq_checker (.*);
